// File: src/ustc_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// ustc_pkg
// Shared widths and types for the seconds-to-calendar converter.
// ============================================================================
package ustc_pkg;

    // Field widths of the item ports
    localparam int SECS_W  = 32;
    localparam int YEAR_W  = 7;
    localparam int MONTH_W = 4;
    localparam int DOM_W   = 5;
    localparam int DOW_W   = 3;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;

    // Internal widths: whole days since epoch (max 49710), second of day (< 86400)
    localparam int DAYS_W = 16;
    localparam int DSEC_W = 17;

    // Stage counts of the day split and date sections, and their sum
    localparam int SPLIT_STAGES = 3;
    localparam int DATE_STAGES  = 6;
    localparam int LATENCY      = SPLIT_STAGES + DATE_STAGES;

    // Day split handed from the front end to the date and clock sections
    typedef struct packed {
        logic [DAYS_W-1:0] days;
        logic [DSEC_W-1:0] dsec;
    } ustc_days_t;

endpackage

// File: src/ustc_day_split.sv
`timescale 1ns / 1ps
// ============================================================================
// ustc_day_split
// Three-stage split of a 32-bit second count into whole days and second of
// day. Divide by 86400 = 128 * 675: shift, reciprocal multiply, fix-up.
// ============================================================================
module ustc_day_split
    import ustc_pkg::*;
(
    input  logic              aclk,
    input  logic              en,
    input  logic [SECS_W-1:0] local_seconds,
    output ustc_days_t        days_out
);

    localparam int SHIFT     = 7;                 // 86400 = 2^7 * 675
    localparam int DIV_W     = SECS_W - SHIFT;    // 25-bit dividend
    localparam int ODD_DIV   = 675;
    localparam int RECIP_K   = 35;
    localparam int RECIP_W   = 26;
    localparam logic [RECIP_W-1:0] RECIP = 26'd50903316;  // floor(2^35 / 675)
    localparam int PROD_W    = DIV_W + RECIP_W;
    localparam int REM0_W    = 11;                // estimate remainder < 2*675
    localparam int REM_W     = 10;                // true remainder < 675

    // Stage 1: quotient estimate, low by at most one
    logic [SECS_W-1:0] secs_reg;
    logic [DAYS_W-1:0] est_reg;
    logic [PROD_W-1:0] prod_next;

    assign prod_next = PROD_W'(local_seconds[SECS_W-1:SHIFT]) * PROD_W'(RECIP);

    always_ff @(posedge aclk) begin
        if (en) begin
            secs_reg <= local_seconds;
            est_reg  <= prod_next[RECIP_K +: DAYS_W];
        end
    end

    // Stage 2: remainder of the estimate
    logic [DAYS_W-1:0] est2_reg;
    logic [REM0_W-1:0] rem0_reg;
    logic [SHIFT-1:0]  low_reg;
    logic [DIV_W:0]    rem0_next;

    assign rem0_next = (DIV_W+1)'(secs_reg[SECS_W-1:SHIFT])
                     - (DIV_W+1)'(est_reg) * (DIV_W+1)'(ODD_DIV);

    always_ff @(posedge aclk) begin
        if (en) begin
            est2_reg <= est_reg;
            rem0_reg <= rem0_next[REM0_W-1:0];
            low_reg  <= secs_reg[SHIFT-1:0];
        end
    end

    // Stage 3: one correction step
    ustc_days_t        days_reg;
    ustc_days_t        days_next;
    logic [REM0_W-1:0] rem_fix;

    always_comb begin
        rem_fix        = rem0_reg;
        days_next.days = est2_reg;
        if (rem0_reg >= REM0_W'(ODD_DIV)) begin
            rem_fix        = rem0_reg - REM0_W'(ODD_DIV);
            days_next.days = est2_reg + DAYS_W'(1);
        end
        days_next.dsec = {rem_fix[REM_W-1:0], low_reg};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            days_reg <= days_next;
        end
    end

    assign days_out = days_reg;

endmodule

// File: src/ustc_date.sv
`timescale 1ns / 1ps
// ============================================================================
// ustc_date
// Six-stage civil-from-days date: 400-year era, March-based year, month
// table lookup, and weekday from the day count.
// ============================================================================
module ustc_date
    import ustc_pkg::*;
(
    input  logic               aclk,
    input  logic               en,
    input  logic [DAYS_W-1:0]  days,
    output logic [YEAR_W-1:0]  year_two_digit,
    output logic [MONTH_W-1:0] month_number,
    output logic [DOM_W-1:0]   day_of_month,
    output logic [DOW_W-1:0]   day_of_week
);

    localparam int DOE_W       = 18;
    localparam int ERA_DAYS    = 146097;
    // 719468 days to 0000-03-01 less four whole eras; the era itself drops
    // out of year mod 100
    localparam int DOE_OFFSET  = 719468 - 4 * ERA_DAYS;
    localparam int CENT_DAYS   = 36524;
    localparam int LAST_DAY    = 146096;
    localparam int R1460       = 367720;   // ceil(2^29 / 1460)
    localparam int R1460_K     = 29;
    localparam int R365        = 367720;   // ceil(2^27 / 365)
    localparam int R365_K      = 27;
    localparam int RECIP_W     = 19;
    localparam int PROD_W      = DOE_W + RECIP_W;
    localparam int QUAD_W      = 8;        // doe / 1460 <= 100
    localparam int CENT_W      = 3;
    localparam int YOE_W       = 9;
    localparam int DOY_W       = 9;
    localparam int MP_W        = 4;
    localparam int NUM_MONTHS  = 12;
    localparam int YEAR_DAYS   = 365;
    localparam int JAN_INDEX   = 10;       // March-based index of January
    localparam int WD_W        = 17;

    // Day of year at which each March-based month starts
    localparam logic [DOY_W-1:0] MONTH_START [NUM_MONTHS] = '{
        9'd0,   9'd31,  9'd61,  9'd92,  9'd122, 9'd153,
        9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
    };

    // (d + 3) mod 7 + 1 by octal digit folding, since 8 = 1 mod 7
    function automatic logic [DOW_W-1:0] weekday(input logic [DAYS_W-1:0] d);
        logic [WD_W-1:0] v;
        logic [5:0]      s1;
        logic [3:0]      s2;
        logic [2:0]      s3;
        v  = WD_W'(d) + WD_W'(3);
        s1 = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9])
           + 6'(v[14:12]) + 6'(v[16:15]);
        s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
        s3 = 3'(s2[3]) + s2[2:0];
        if (s3 == 3'd7) begin
            s3 = 3'd0;
        end
        return s3 + 3'd1;
    endfunction

    // Stage 1: day of era, weekday
    logic [DOE_W-1:0] doe1_reg, doe1_next;
    logic [DOW_W-1:0] wd1_reg;

    always_comb begin
        doe1_next = DOE_W'(days) + DOE_W'(DOE_OFFSET);
        if (doe1_next >= DOE_W'(ERA_DAYS)) begin
            doe1_next = doe1_next - DOE_W'(ERA_DAYS);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            doe1_reg <= doe1_next;
            wd1_reg  <= weekday(days);
        end
    end

    // Stage 2: four-year, century and last-day terms
    logic [DOE_W-1:0]  doe2_reg;
    logic [DOW_W-1:0]  wd2_reg;
    logic [QUAD_W-1:0] quad_reg;
    logic [CENT_W-1:0] cent_reg, cent_next;
    logic              last_reg;
    logic [PROD_W-1:0] quad_prod;

    assign quad_prod = PROD_W'(doe1_reg) * PROD_W'(R1460);

    always_comb begin
        cent_next = '0;
        for (int i = 1; i <= 4; i++) begin
            if (doe1_reg >= DOE_W'(i * CENT_DAYS)) begin
                cent_next = CENT_W'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            doe2_reg <= doe1_reg;
            wd2_reg  <= wd1_reg;
            quad_reg <= quad_prod[R1460_K +: QUAD_W];
            cent_reg <= cent_next;
            last_reg <= (doe1_reg >= DOE_W'(LAST_DAY));
        end
    end

    // Stage 3: leap-corrected day count
    logic [DOE_W-1:0] doe3_reg;
    logic [DOW_W-1:0] wd3_reg;
    logic [DOE_W-1:0] adj_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            doe3_reg <= doe2_reg;
            wd3_reg  <= wd2_reg;
            adj_reg  <= doe2_reg - DOE_W'(quad_reg) + DOE_W'(cent_reg)
                      - DOE_W'(last_reg);
        end
    end

    // Stage 4: year of era = adj / 365
    logic [DOE_W-1:0]  doe4_reg;
    logic [DOW_W-1:0]  wd4_reg;
    logic [YOE_W-1:0]  yoe_reg;
    logic [PROD_W-1:0] yoe_prod;

    assign yoe_prod = PROD_W'(adj_reg) * PROD_W'(R365);

    always_ff @(posedge aclk) begin
        if (en) begin
            doe4_reg <= doe3_reg;
            wd4_reg  <= wd3_reg;
            yoe_reg  <= yoe_prod[R365_K +: YOE_W];
        end
    end

    // Stage 5: day of year and year mod 100
    logic [DOW_W-1:0]  wd5_reg;
    logic [DOY_W-1:0]  doy_reg;
    logic [YEAR_W-1:0] yy_reg;
    logic [1:0]        yc;
    logic [DOE_W-1:0]  year_start;
    logic [DOE_W-1:0]  doy_full;
    logic [YOE_W-1:0]  yy_full;

    always_comb begin
        yc = 2'd0;
        if (yoe_reg >= YOE_W'(300)) begin
            yc = 2'd3;
        end else if (yoe_reg >= YOE_W'(200)) begin
            yc = 2'd2;
        end else if (yoe_reg >= YOE_W'(100)) begin
            yc = 2'd1;
        end
        year_start = DOE_W'(yoe_reg) * DOE_W'(YEAR_DAYS)
                   + DOE_W'(yoe_reg[YOE_W-1:2]) - DOE_W'(yc);
        doy_full   = doe4_reg - year_start;
        yy_full    = yoe_reg - YOE_W'(yc) * YOE_W'(100);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            wd5_reg <= wd4_reg;
            doy_reg <= doy_full[DOY_W-1:0];
            yy_reg  <= yy_full[YEAR_W-1:0];
        end
    end

    // Stage 6: month lookup, day of month, January/February year carry
    logic [YEAR_W-1:0]  year_reg, year_next;
    logic [MONTH_W-1:0] month_reg, month_next;
    logic [DOM_W-1:0]   dom_reg;
    logic [DOW_W-1:0]   wd_reg;
    logic [MP_W-1:0]    mp;
    logic [DOY_W-1:0]   dom_full;

    always_comb begin
        mp = '0;
        for (int i = 1; i < NUM_MONTHS; i++) begin
            if (doy_reg >= MONTH_START[i]) begin
                mp = MP_W'(i);
            end
        end
        dom_full  = doy_reg - MONTH_START[mp] + DOY_W'(1);
        year_next = yy_reg;
        if (mp >= MP_W'(JAN_INDEX)) begin
            month_next = mp - MP_W'(9);
            year_next  = (yy_reg == YEAR_W'(99)) ? '0 : yy_reg + YEAR_W'(1);
        end else begin
            month_next = mp + MP_W'(3);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            year_reg  <= year_next;
            month_reg <= month_next;
            dom_reg   <= dom_full[DOM_W-1:0];
            wd_reg    <= wd5_reg;
        end
    end

    assign year_two_digit = year_reg;
    assign month_number   = month_reg;
    assign day_of_month   = dom_reg;
    assign day_of_week    = wd_reg;

endmodule

// File: src/ustc_clock.sv
`timescale 1ns / 1ps
// ============================================================================
// ustc_clock
// Six-stage split of the second of day into hour, minute and second,
// aligned with the date section.
// ============================================================================
module ustc_clock
    import ustc_pkg::*;
(
    input  logic              aclk,
    input  logic              en,
    input  logic [DSEC_W-1:0] dsec,
    output logic [HOUR_W-1:0] hour_of_day,
    output logic [MIN_W-1:0]  minute_of_hour,
    output logic [SEC_W-1:0]  second_of_minute
);

    localparam int SECS_PER_HOUR = 3600;
    localparam int SECS_PER_MIN  = 60;
    localparam int RH            = 149131;  // ceil(2^29 / 3600)
    localparam int RH_K          = 29;
    localparam int RH_W          = 18;
    localparam int HPROD_W       = DSEC_W + RH_W;
    localparam int REM_W         = 12;      // < 3600
    localparam int RM            = 4370;    // ceil(2^18 / 60)
    localparam int RM_K          = 18;
    localparam int RM_W          = 13;
    localparam int MPROD_W       = REM_W + RM_W;

    // Stage 1: hour = dsec / 3600
    logic [DSEC_W-1:0]  dsec1_reg;
    logic [HOUR_W-1:0]  hour1_reg;
    logic [HPROD_W-1:0] hprod;

    assign hprod = HPROD_W'(dsec) * HPROD_W'(RH);

    always_ff @(posedge aclk) begin
        if (en) begin
            dsec1_reg <= dsec;
            hour1_reg <= hprod[RH_K +: HOUR_W];
        end
    end

    // Stage 2: second within the hour
    logic [HOUR_W-1:0] hour2_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [DSEC_W-1:0] rem_full;

    assign rem_full = dsec1_reg - DSEC_W'(hour1_reg) * DSEC_W'(SECS_PER_HOUR);

    always_ff @(posedge aclk) begin
        if (en) begin
            hour2_reg <= hour1_reg;
            rem_reg   <= rem_full[REM_W-1:0];
        end
    end

    // Stage 3: minute = rem / 60
    logic [HOUR_W-1:0]  hour3_reg;
    logic [REM_W-1:0]   rem3_reg;
    logic [MIN_W-1:0]   min3_reg;
    logic [MPROD_W-1:0] mprod;

    assign mprod = MPROD_W'(rem_reg) * MPROD_W'(RM);

    always_ff @(posedge aclk) begin
        if (en) begin
            hour3_reg <= hour2_reg;
            rem3_reg  <= rem_reg;
            min3_reg  <= mprod[RM_K +: MIN_W];
        end
    end

    // Stage 4: second within the minute
    logic [HOUR_W-1:0] hour4_reg;
    logic [MIN_W-1:0]  min4_reg;
    logic [SEC_W-1:0]  sec4_reg;
    logic [REM_W-1:0]  sec_full;

    assign sec_full = rem3_reg - REM_W'(min3_reg) * REM_W'(SECS_PER_MIN);

    always_ff @(posedge aclk) begin
        if (en) begin
            hour4_reg <= hour3_reg;
            min4_reg  <= min3_reg;
            sec4_reg  <= sec_full[SEC_W-1:0];
        end
    end

    // Stages 5 and 6: delay to line up with the date section
    logic [HOUR_W-1:0] hour5_reg, hour_reg;
    logic [MIN_W-1:0]  min5_reg, min_reg;
    logic [SEC_W-1:0]  sec5_reg, sec_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            hour5_reg <= hour4_reg;
            min5_reg  <= min4_reg;
            sec5_reg  <= sec4_reg;
            hour_reg  <= hour5_reg;
            min_reg   <= min5_reg;
            sec_reg   <= sec5_reg;
        end
    end

    assign hour_of_day      = hour_reg;
    assign minute_of_hour   = min_reg;
    assign second_of_minute = sec_reg;

endmodule

// File: src/unix_seconds_to_calendar.sv
`timescale 1ns / 1ps
// Accepted inputs pass the day split, date and clock stages to the m_ side.
// Throughput: one item per cycle; every stage is a plain register stage and
// the whole pipe advances together, holding when the result is not taken.
// Reset (aresetn low at a clock edge) clears only the stage valid bits;
// data registers are not reset.
// ============================================================================
// unix_seconds_to_calendar
// Local Unix seconds to two-digit year, month, day, weekday and time of day.
// ============================================================================
module unix_seconds_to_calendar
    import ustc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [SECS_W-1:0]  s_local_seconds,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [YEAR_W-1:0]  m_year_two_digit,
    output logic [MONTH_W-1:0] m_month_number,
    output logic [DOM_W-1:0]   m_day_of_month,
    output logic [DOW_W-1:0]   m_day_of_week,
    output logic [HOUR_W-1:0]  m_hour_of_day,
    output logic [MIN_W-1:0]   m_minute_of_hour,
    output logic [SEC_W-1:0]   m_second_of_minute
);

    // Stage valid bits; the pipe moves when the last stage is empty or taken
    logic [LATENCY-1:0] valid_reg, valid_next;
    logic               en;

    assign en         = !valid_reg[LATENCY-1] || m_ready;
    assign valid_next = {valid_reg[LATENCY-2:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = en;
    assign m_valid = valid_reg[LATENCY-1];

    // Days and second of day
    ustc_days_t split;

    ustc_day_split u_split (
        .aclk          (aclk),
        .en            (en),
        .local_seconds (s_local_seconds),
        .days_out      (split)
    );

    // Calendar date and weekday
    ustc_date u_date (
        .aclk           (aclk),
        .en             (en),
        .days           (split.days),
        .year_two_digit (m_year_two_digit),
        .month_number   (m_month_number),
        .day_of_month   (m_day_of_month),
        .day_of_week    (m_day_of_week)
    );

    // Time of day
    ustc_clock u_clock (
        .aclk             (aclk),
        .en               (en),
        .dsec             (split.dsec),
        .hour_of_day      (m_hour_of_day),
        .minute_of_hour   (m_minute_of_hour),
        .second_of_minute (m_second_of_minute)
    );

endmodule
